[sv/serial_register_bus_transaction_assert.svh]
// Assertion macros used by the register bus transaction RTL (srb_emit).
`ifndef SERIAL_REGISTER_BUS_TRANSACTION_ASSERT_SVH
`define SERIAL_REGISTER_BUS_TRANSACTION_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/srb_pkg.sv]
// Types, codes and helpers for the register bus transaction master.
`timescale 1ns / 1ps
package srb_pkg;

	// command kinds on the start word
	localparam logic [1:0] CK_READ   = 2'd0;
	localparam logic [1:0] CK_WRITE  = 2'd1;
	localparam logic [1:0] CK_BRIGHT = 2'd2;
	localparam logic [1:0] CK_NONE   = 2'd3;

	// word modes
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_RX    = 1'b1;

	// command codes on the line
	localparam logic [7:0] CMD_READ   = 8'h05;
	localparam logic [7:0] CMD_WRITE  = 8'h06;
	localparam logic [7:0] CMD_BRIGHT = 8'h0a;
	localparam logic [7:0] SYNC_BYTE  = 8'hff;

	// body bytes before the checksum byte
	localparam logic [2:0] BODY_LEN  = 3'd5;
	localparam logic [2:0] STORE_LEN = 3'd4;
	localparam logic [2:0] REQ_LAST  = 3'd7;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_CHECKSUM = 3'd1,
		ST_COMMAND  = 3'd2,
		ST_MODULE   = 3'd3,
		ST_REGISTER = 3'd4,
		ST_VALUE    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PH_SYNC1 = 2'd0,
		PH_SYNC2 = 2'd1,
		PH_BODY  = 2'd2,
		PH_CSUM  = 2'd3
	} phase_t;

	// one accepted input word
	typedef struct packed {
		logic       mode;
		logic [1:0] command_kind;
		logic [7:0] module_address;
		logic [7:0] register_address;
		logic [7:0] write_value;
		logic [7:0] rx_byte;
	} item_t;

	// result descriptor: a request burst or a completion
	typedef struct packed {
		logic       done;
		logic [7:0] cmd;
		logic [7:0] module_address;
		logic [7:0] value;
		logic [7:0] register_address;
		logic [7:0] csum;
		status_t    status;
		logic [7:0] read_value;
	} desc_t;

	function automatic logic [7:0] cmd_code(input logic [1:0] ck);
		logic [7:0] c;
		case (ck)
			CK_READ:  c = CMD_READ;
			CK_WRITE: c = CMD_WRITE;
			default:  c = CMD_BRIGHT;
		endcase
		return c;
	endfunction

endpackage

[sv/srb_if.sv]
// Valid/ready channel interfaces for input words and result words.
`timescale 1ns / 1ps
interface srb_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [1:0] command_kind;
	logic [7:0] module_address;
	logic [7:0] register_address;
	logic [7:0] write_value;
	logic [7:0] rx_byte;

	modport source (output valid, mode, command_kind, module_address, register_address,
		write_value, rx_byte, input ready);
	modport sink (input valid, mode, command_kind, module_address, register_address,
		write_value, rx_byte, output ready);
endinterface

interface srb_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] tx_byte;
	logic       last;
	logic [2:0] status;
	logic [7:0] read_value;

	modport source (output valid, kind, tx_byte, last, status, read_value, input ready);
	modport sink (input valid, kind, tx_byte, last, status, read_value, output ready);
endinterface

[sv/srb_core.sv]
// Transaction state and response deframer; builds the result descriptors.
`timescale 1ns / 1ps
module srb_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           acc,
	input  srb_pkg::item_t item,
	output logic           emit,
	output srb_pkg::desc_t desc
);
	import srb_pkg::*;

	logic       pending_q, is_read_q;
	logic [7:0] exp_cmd_q, exp_reg_q, exp_val_q;
	phase_t     phase_q;
	logic [2:0] idx_q;
	logic [7:0] sum_q;
	logic [7:0] body_q [4];

	logic       n_pending, n_is_read;
	logic [7:0] n_exp_cmd, n_exp_reg, n_exp_val;
	phase_t     n_phase;
	logic [2:0] n_idx;
	logic [7:0] n_sum;
	logic       body_we;
	logic [7:0] cmd, b1;
	logic       start_ok;
	status_t    status;

	// request fields of a start word
	always_comb begin
		cmd = cmd_code(item.command_kind);
		b1 = (item.command_kind == CK_READ) ? 8'h00 : item.write_value;
		start_ok = (item.command_kind != CK_NONE);
	end

	// next state
	always_comb begin
		n_pending = pending_q;
		n_is_read = is_read_q;
		n_exp_cmd = exp_cmd_q;
		n_exp_reg = exp_reg_q;
		n_exp_val = exp_val_q;
		n_phase = phase_q;
		n_idx = idx_q;
		n_sum = sum_q;
		body_we = 1'b0;
		if (acc) begin
			if (item.mode == MODE_START) begin
				if (start_ok) begin
					n_pending = 1'b1;
					n_is_read = (item.command_kind == CK_READ);
					n_exp_cmd = cmd;
					n_exp_reg = item.register_address;
					n_exp_val = b1;
					n_phase = PH_SYNC1;
					n_idx = 3'd0;
					n_sum = 8'h00;
				end
			end else if (pending_q) begin
				case (phase_q)
					PH_SYNC1: begin
						if (item.rx_byte == SYNC_BYTE)
							n_phase = PH_SYNC2;
					end
					PH_SYNC2: begin
						if (item.rx_byte == SYNC_BYTE) begin
							n_phase = PH_BODY;
							n_idx = 3'd0;
							n_sum = 8'h00;
						end else begin
							n_phase = PH_SYNC1;
						end
					end
					PH_BODY: begin
						body_we = (idx_q < STORE_LEN);
						n_sum = sum_q + item.rx_byte;
						n_idx = idx_q + 3'd1;
						if (n_idx >= BODY_LEN)
							n_phase = PH_CSUM;
					end
					default: begin
						n_pending = 1'b0;
						n_phase = PH_SYNC1;
						n_idx = 3'd0;
						n_sum = 8'h00;
					end
				endcase
			end
		end
	end

	// completion status, in priority order
	always_comb begin
		if (item.rx_byte != sum_q)
			status = ST_CHECKSUM;
		else if (body_q[0] != exp_cmd_q)
			status = ST_COMMAND;
		else if (body_q[1] != 8'h00)
			status = ST_MODULE;
		else if (body_q[3] != exp_reg_q)
			status = ST_REGISTER;
		else if (!is_read_q && body_q[2] != exp_val_q)
			status = ST_VALUE;
		else
			status = ST_OK;
	end

	// outputs: descriptor and its strobe
	always_comb begin
		desc = '0;
		emit = 1'b0;
		if (item.mode == MODE_START) begin
			emit = acc && start_ok;
			desc.cmd = cmd;
			desc.module_address = item.module_address;
			desc.value = b1;
			desc.register_address = item.register_address;
			desc.csum = cmd + item.module_address + b1 + item.register_address;
		end else begin
			emit = acc && pending_q && (phase_q == PH_CSUM);
			desc.done = 1'b1;
			desc.status = status;
			desc.read_value = (status == ST_OK && is_read_q) ? body_q[2] : 8'h00;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			is_read_q <= 1'b0;
			exp_cmd_q <= 8'h00;
			exp_reg_q <= 8'h00;
			exp_val_q <= 8'h00;
			phase_q <= PH_SYNC1;
			idx_q <= 3'd0;
			sum_q <= 8'h00;
		end else begin
			pending_q <= n_pending;
			is_read_q <= n_is_read;
			exp_cmd_q <= n_exp_cmd;
			exp_reg_q <= n_exp_reg;
			exp_val_q <= n_exp_val;
			phase_q <= n_phase;
			idx_q <= n_idx;
			sum_q <= n_sum;
		end
	end

	// stored body bytes: echo, module, value, register
	always_ff @(posedge clk) begin
		if (body_we)
			body_q[idx_q[1:0]] <= item.rx_byte;
	end

endmodule

[sv/srb_emit.sv]
// Skid stage and word serializer for request bursts and completions.
`timescale 1ns / 1ps
module srb_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           emit,
	input  srb_pkg::desc_t desc,
	output logic           take,
	srb_out_if.source      result
);
	import srb_pkg::*;
	`include "serial_register_bus_transaction_assert.svh"

	logic       s1_valid_q;
	desc_t      s1_q;
	logic       busy_q;
	desc_t      cur_q;
	logic [2:0] idx_q;
	logic       fin, free, handoff;
	logic [7:0] req_byte;

	// burst end and handoff from the skid stage
	assign fin = busy_q && result.ready && result.last;
	assign free = !busy_q || fin;
	assign handoff = s1_valid_q && free;
	assign take = !s1_valid_q || free;

	// request byte for the current position
	always_comb begin
		case (idx_q)
			3'd0, 3'd1: req_byte = SYNC_BYTE;
			3'd2:       req_byte = cur_q.cmd;
			3'd3:       req_byte = cur_q.module_address;
			3'd4:       req_byte = cur_q.value;
			3'd5:       req_byte = cur_q.register_address;
			3'd6:       req_byte = 8'h00;
			default:    req_byte = cur_q.csum;
		endcase
	end

	// result word
	assign result.valid = busy_q;
	assign result.kind = cur_q.done;
	assign result.tx_byte = cur_q.done ? 8'h00 : req_byte;
	assign result.last = cur_q.done || (idx_q == REQ_LAST);
	assign result.status = cur_q.done ? cur_q.status : ST_OK;
	assign result.read_value = cur_q.done ? cur_q.read_value : 8'h00;

	// skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (emit) begin
			s1_valid_q <= 1'b1;
		end else if (handoff) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			s1_q <= desc;
	end

	// serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= 3'd0;
		end else if (handoff) begin
			busy_q <= 1'b1;
			idx_q <= 3'd0;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (busy_q && result.ready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (handoff)
			cur_q <= s1_q;
	end

	`SRB_ASSERT_IMP(a_emit_taken, clk, arst_n, emit, take, "descriptor emitted while stage full")
	`SRB_ASSERT_NXT(a_skid_hold, clk, arst_n, s1_valid_q && !handoff, s1_valid_q && $stable(s1_q), "skid descriptor lost")
	`SRB_ASSERT_IMP(a_done_single, clk, arst_n, busy_q && idx_q != 3'd0, !cur_q.done, "completion spans several words")
	`SRB_ASSERT_NXT(a_burst_step, clk, arst_n, busy_q && !cur_q.done && result.ready && idx_q != REQ_LAST, busy_q && idx_q == $past(idx_q) + 3'd1, "request burst skipped a byte")

endmodule

[sv/serial_register_bus_transaction.sv]
// Flow: an accepted word's result descriptor is registered in the skid stage, then moves
// into the serializer once that is free; the next descriptor may wait in the skid stage.
// Throughput: one input word per cycle while the skid stage can take it; a start word produces
// 8 result words, one per cycle while result.ready is high; a checksum byte yields one word.
// Reset: arst_n clears the pending transaction, deframer phase, counters and both stages.
`timescale 1ns / 1ps
module serial_register_bus_transaction (
	input  logic      clk,
	input  logic      arst_n,
	srb_in_if.sink    item,
	srb_out_if.source result
);
	import srb_pkg::*;

	item_t item_w;
	logic  acc, emit, take;
	desc_t desc;

	// input word
	always_comb begin
		item_w.mode = item.mode;
		item_w.command_kind = item.command_kind;
		item_w.module_address = item.module_address;
		item_w.register_address = item.register_address;
		item_w.write_value = item.write_value;
		item_w.rx_byte = item.rx_byte;
	end

	assign item.ready = take;
	assign acc = item.valid && take;

	srb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.item   (item_w),
		.emit   (emit),
		.desc   (desc)
	);

	srb_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.emit   (emit),
		.desc   (desc),
		.take   (take),
		.result (result)
	);

endmodule

[dv/tb_serial_register_bus_transaction.sv]
// Self-checking bench for the register bus master: request framing and response deframing.
`timescale 1ns / 1ps
module tb_serial_register_bus_transaction;
	import srb_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 11;
	localparam int HOLD_CYCLES = 150;
	localparam int WATCHDOG = 1000;
	localparam int SETTLE_CYCLES = 20;

	// fault bits used when building a response frame
	localparam int FLT_CSUM = 0;
	localparam int FLT_CMD = 1;
	localparam int FLT_MODULE = 2;
	localparam int FLT_REG = 3;
	localparam int FLT_VALUE = 4;

	// one word on the result channel
	typedef struct packed {
		logic       kind;
		logic [7:0] tx_byte;
		logic       last;
		status_t    status;
		logic [7:0] read_value;
	} bus_word_t;

	logic clk = 1'b0;
	logic arst_n;

	srb_in_if item_ch ();
	srb_out_if result_ch ();

	serial_register_bus_transaction DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// words the block still owes, oldest first
	bus_word_t bus_words_due[$];
	bus_word_t want_word;

	// mirror of the master's transaction and deframer state
	logic       txn_open;
	logic       want_read;
	logic [7:0] want_cmd;
	logic [7:0] want_reg;
	logic [7:0] want_val;
	phase_t     rx_phase;
	logic [2:0] body_cnt;
	logic [7:0] body_sum;
	logic [7:0] body_seen [4];

	int mismatches = 0;
	int useful_words = 0;
	int requests_sent = 0;
	int words_checked = 0;
	int status_tally [6] = '{default: 0};
	int idle_cycles = 0;

	bit sender_gaps = 1'b1;
	bit receiver_gaps = 1'b1;
	bit hold_req = 1'b0;
	bit hold_active = 1'b0;

	// advance the master by one accepted word; returns 0 when the word is ignored
	function automatic bit bus_master_step(input item_t w);
		logic [7:0] cmd;
		logic [7:0] b1;
		logic [7:0] frame [8];
		logic [7:0] rv;
		status_t st;
		bus_word_t r;
		if (w.mode == MODE_START) begin
			if (w.command_kind == CK_NONE)
				return 1'b0;
			case (w.command_kind)
				CK_READ:  cmd = CMD_READ;
				CK_WRITE: cmd = CMD_WRITE;
				default:  cmd = CMD_BRIGHT;
			endcase
			b1 = (w.command_kind == CK_READ) ? 8'h00 : w.write_value;
			frame[0] = SYNC_BYTE;
			frame[1] = SYNC_BYTE;
			frame[2] = cmd;
			frame[3] = w.module_address;
			frame[4] = b1;
			frame[5] = w.register_address;
			frame[6] = 8'h00;
			frame[7] = cmd + w.module_address + b1 + w.register_address;
			for (int i = 0; i < 8; i++) begin
				r.kind = 1'b0;
				r.tx_byte = frame[i];
				r.last = (i == 7);
				r.status = ST_OK;
				r.read_value = 8'h00;
				bus_words_due.push_back(r);
			end
			// a new start abandons whatever was pending
			txn_open = 1'b1;
			want_read = (w.command_kind == CK_READ);
			want_cmd = cmd;
			want_reg = w.register_address;
			want_val = b1;
			rx_phase = PH_SYNC1;
			body_cnt = 3'd0;
			body_sum = 8'h00;
			requests_sent++;
			return 1'b1;
		end
		if (!txn_open)
			return 1'b0;
		case (rx_phase)
			PH_SYNC1: begin
				if (w.rx_byte == SYNC_BYTE)
					rx_phase = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (w.rx_byte == SYNC_BYTE) begin
					rx_phase = PH_BODY;
					body_cnt = 3'd0;
					body_sum = 8'h00;
				end else begin
					rx_phase = PH_SYNC1;
				end
			end
			PH_BODY: begin
				if (body_cnt < STORE_LEN)
					body_seen[body_cnt[1:0]] = w.rx_byte;
				body_sum = body_sum + w.rx_byte;
				body_cnt = body_cnt + 3'd1;
				if (body_cnt >= BODY_LEN)
					rx_phase = PH_CSUM;
			end
			default: begin
				// checks in priority order
				if (w.rx_byte != body_sum)
					st = ST_CHECKSUM;
				else if (body_seen[0] != want_cmd)
					st = ST_COMMAND;
				else if (body_seen[1] != 8'h00)
					st = ST_MODULE;
				else if (body_seen[3] != want_reg)
					st = ST_REGISTER;
				else if (!want_read && body_seen[2] != want_val)
					st = ST_VALUE;
				else
					st = ST_OK;
				rv = (st == ST_OK && want_read) ? body_seen[2] : 8'h00;
				r.kind = 1'b1;
				r.tx_byte = 8'h00;
				r.last = 1'b1;
				r.status = st;
				r.read_value = rv;
				bus_words_due.push_back(r);
				status_tally[st]++;
				txn_open = 1'b0;
				rx_phase = PH_SYNC1;
				body_cnt = 3'd0;
				body_sum = 8'h00;
			end
		endcase
		return 1'b1;
	endfunction

	// offer one input word and wait until it is taken
	task automatic send_word(input item_t w);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode <= w.mode;
		item_ch.command_kind <= w.command_kind;
		item_ch.module_address <= w.module_address;
		item_ch.register_address <= w.register_address;
		item_ch.write_value <= w.write_value;
		item_ch.rx_byte <= w.rx_byte;
		do @(posedge clk); while (!item_ch.ready);
		if (bus_master_step(w))
			useful_words++;
	endtask

	task automatic send_start(input logic [1:0] ck, input logic [7:0] mod_a,
		input logic [7:0] reg_a, input logic [7:0] val);
		item_t w;
		w.mode = MODE_START;
		w.command_kind = ck;
		w.module_address = mod_a;
		w.register_address = reg_a;
		w.write_value = val;
		w.rx_byte = 8'($urandom_range(0, 255));
		send_word(w);
	endtask

	// received line byte; the unused fields carry noise
	task automatic send_rx(input logic [7:0] b);
		item_t w;
		w.mode = MODE_RX;
		w.command_kind = 2'($urandom_range(0, 3));
		w.module_address = 8'($urandom_range(0, 255));
		w.register_address = 8'($urandom_range(0, 255));
		w.write_value = 8'($urandom_range(0, 255));
		w.rx_byte = b;
		send_word(w);
	endtask

	// response frame with optional faults and some sync noise ahead of it
	task automatic send_reply(input logic [7:0] cmd, input logic [7:0] reg_a,
		input logic [7:0] val, input logic [4:0] faults, input int noise);
		logic [7:0] body [5];
		logic [7:0] sum;
		body[0] = cmd;
		body[1] = 8'h00;
		body[2] = val;
		body[3] = reg_a;
		body[4] = 8'($urandom_range(0, 255));
		if (faults[FLT_CMD])
			body[0] = body[0] ^ 8'($urandom_range(1, 255));
		if (faults[FLT_MODULE])
			body[1] = 8'($urandom_range(1, 255));
		if (faults[FLT_REG])
			body[3] = body[3] ^ 8'($urandom_range(1, 255));
		if (faults[FLT_VALUE])
			body[2] = body[2] ^ 8'($urandom_range(1, 255));
		sum = body[0] + body[1] + body[2] + body[3] + body[4];
		if (faults[FLT_CSUM])
			sum = sum ^ 8'($urandom_range(1, 255));
		for (int i = 0; i < noise; i++) begin
			if ($urandom_range(0, 1)) begin
				send_rx(8'($urandom_range(0, 254)));
			end else begin
				send_rx(SYNC_BYTE);
				send_rx(8'($urandom_range(0, 254)));
			end
		end
		send_rx(SYNC_BYTE);
		send_rx(SYNC_BYTE);
		for (int i = 0; i < 5; i++)
			send_rx(body[i]);
		send_rx(sum);
	endtask

	// stop offering and wait until every owed word has come out
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (bus_words_due.size() != 0)
			@(posedge clk);
	endtask

	// bytes with nothing pending and the unused command kind
	task automatic test_dropped_words();
		send_start(CK_NONE, 8'hff, 8'hff, 8'hff);
		send_rx(SYNC_BYTE);
		send_rx(8'h00);
		drain();
	endtask

	// read with both kinds of sync loss ahead of a clean response
	task automatic test_read_frame();
		send_start(CK_READ, 8'h00, 8'h00, 8'hff);
		send_rx(8'h00);
		send_rx(SYNC_BYTE);
		send_rx(8'h7e);
		send_reply(CMD_READ, 8'h00, 8'hff, 5'd0, 0);
		drain();
	endtask

	// brightness abandoned mid-sync, then a write whose response breaks every check
	task automatic test_abandon_and_priority();
		send_start(CK_BRIGHT, 8'hff, 8'hff, 8'hff);
		send_rx(SYNC_BYTE);
		send_start(CK_WRITE, 8'h00, 8'h00, 8'h00);
		send_reply(CMD_WRITE, 8'h00, 8'h00, 5'b11111, 0);
		drain();
	endtask

	// long result stall while requests keep coming, so the input backs up
	task automatic test_backpressure();
		sender_gaps = 1'b0;
		hold_req = 1'b1;
		@(posedge clk);
		while (!hold_active)
			@(posedge clk);
		repeat (6)
			send_start(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		sender_gaps = 1'b1;
		drain();
	endtask

	// mostly well-formed transactions with random content, some noise and broken frames
	task automatic test_random_traffic(input int n_words);
		int goal;
		int pick;
		logic [1:0] ck;
		logic [7:0] mod_a;
		logic [7:0] reg_a;
		logic [7:0] val;
		logic [7:0] echo;
		logic [7:0] back;
		logic [4:0] faults;
		goal = useful_words + n_words;
		while (useful_words < goal) begin
			if ($urandom_range(0, 19) == 0)
				ck = CK_NONE;
			else
				ck = 2'($urandom_range(0, 2));
			mod_a = 8'($urandom_range(0, 255));
			reg_a = 8'($urandom_range(0, 255));
			val = 8'($urandom_range(0, 255));
			send_start(ck, mod_a, reg_a, val);
			case (ck)
				CK_READ:  echo = CMD_READ;
				CK_WRITE: echo = CMD_WRITE;
				default:  echo = CMD_BRIGHT;
			endcase
			back = (ck == CK_READ) ? 8'($urandom_range(0, 255)) : val;
			pick = (ck == CK_NONE) ? 8 : $urandom_range(0, 9);
			if (pick <= 6) begin
				faults = 5'd0;
				if ($urandom_range(0, 2) == 0)
					faults = 5'($urandom_range(1, 31));
				send_reply(echo, reg_a, back, faults, $urandom_range(0, 2));
				if ($urandom_range(0, 4) == 0)
					send_rx(8'($urandom_range(0, 255)));
			end else if (pick == 7) begin
				// frame cut short, the next start abandons it
				send_rx(SYNC_BYTE);
				send_rx(SYNC_BYTE);
				repeat ($urandom_range(1, 5))
					send_rx(8'($urandom_range(0, 255)));
			end else if (pick == 8) begin
				repeat ($urandom_range(1, 10))
					send_rx(8'($urandom_range(0, 255)));
			end
		end
		drain();
	endtask

	// result side ready: random stalls, ready stretches, one long hold on request
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_active = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				if (receiver_gaps && $urandom_range(0, 3) == 0)
					repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	// compare each accepted result word with the oldest owed word
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			if (bus_words_due.size() == 0) begin
				$error("result word with nothing owed: kind %0d tx_byte %02h status %0d",
					result_ch.kind, result_ch.tx_byte, result_ch.status);
				mismatches++;
			end else begin
				want_word = bus_words_due.pop_front();
				words_checked++;
				if (result_ch.kind !== want_word.kind) begin
					$error("kind: expected %0d, got %0d", want_word.kind, result_ch.kind);
					mismatches++;
				end
				if (result_ch.tx_byte !== want_word.tx_byte) begin
					$error("tx_byte: expected %02h, got %02h", want_word.tx_byte,
						result_ch.tx_byte);
					mismatches++;
				end
				if (result_ch.last !== want_word.last) begin
					$error("last: expected %0d, got %0d", want_word.last, result_ch.last);
					mismatches++;
				end
				if (result_ch.status !== want_word.status) begin
					$error("status: expected %0d, got %0d", want_word.status,
						result_ch.status);
					mismatches++;
				end
				if (result_ch.read_value !== want_word.read_value) begin
					$error("read_value: expected %02h, got %02h", want_word.read_value,
						result_ch.read_value);
					mismatches++;
				end
			end
		end
	end

	// end the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG);
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// test sequence
	initial begin
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.mode <= MODE_START;
		item_ch.command_kind <= CK_NONE;
		item_ch.module_address <= 8'h00;
		item_ch.register_address <= 8'h00;
		item_ch.write_value <= 8'h00;
		item_ch.rx_byte <= 8'h00;
		txn_open = 1'b0;
		want_read = 1'b0;
		want_cmd = 8'h00;
		want_reg = 8'h00;
		want_val = 8'h00;
		rx_phase = PH_SYNC1;
		body_cnt = 3'd0;
		body_sum = 8'h00;
		body_seen = '{default: 8'h00};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_dropped_words();
		test_read_frame();
		test_abandon_and_priority();
		test_backpressure();
		test_random_traffic(240);

		// closing stretch at full rate on both sides
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		test_random_traffic(60);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bus_words_due.size() != 0) begin
			$error("%0d result words never arrived", bus_words_due.size());
			mismatches++;
		end
		$display("Covered %0d effective input words, %0d requests, %0d result words checked.",
			useful_words, requests_sent, words_checked);
		$display("Completions ok/checksum/command/module/register/value: %0d/%0d/%0d/%0d/%0d/%0d",
			status_tally[ST_OK], status_tally[ST_CHECKSUM], status_tally[ST_COMMAND],
			status_tally[ST_MODULE], status_tally[ST_REGISTER], status_tally[ST_VALUE]);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
